// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared sizes, codes and interface types for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PRIO_WIDTH = 16;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // operation codes on in_func
  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    CTL_IDLE,
    CTL_HOLD
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic exec;   // carry out the accepted item and load the result register
  } spq_cmd_t;

endpackage

// ===== rtl/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: tracks whether a result is held and issues commands.
// ----------------------------------------------------------------------------
module spq_ctrl import spq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output spq_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;
  logic       accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CTL_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a held result that is not being taken blocks the input side
  assign in_stall = (state_r == CTL_HOLD) && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CTL_IDLE: begin
        if (accept) state_nxt = CTL_HOLD;
      end
      CTL_HOLD: begin
        if (!out_stall && !accept) state_nxt = CTL_IDLE;
      end
      default: state_nxt = CTL_IDLE;
    endcase
  end

  always_comb begin
    cmd.exec  = accept;
    out_valid = (state_r == CTL_HOLD);
  end

endmodule

// ===== rtl/spq_datapath.sv =====
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted entry store with parallel compare-and-shift, plus result register.
// ----------------------------------------------------------------------------
module spq_datapath import spq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  spq_cmd_t    cmd,
  input  logic        in_func,
  input  logic [31:0] in_value,
  input  logic [15:0] in_priority_req,
  output logic [31:0] out_value,
  output logic [1:0]  out_status,
  output logic [4:0]  out_occupancy
);

  logic [DATA_WIDTH-1:0] val_r   [CAPACITY];
  logic [PRIO_WIDTH-1:0] prio_r  [CAPACITY];
  logic [DATA_WIDTH-1:0] val_nxt [CAPACITY];
  logic [PRIO_WIDTH-1:0] prio_nxt[CAPACITY];
  logic [CNT_W-1:0]      count_r, count_nxt;

  logic [DATA_WIDTH-1:0] res_value_r, res_value_nxt;
  status_t               res_status_r, res_status_nxt;
  logic [CNT_W-1:0]      res_count_r;

  logic [DATA_WIDTH-1:0] new_val;
  logic [PRIO_WIDTH-1:0] new_prio;
  logic [CAPACITY-1:0]   ins_mask;
  logic [CAPACITY-1:0]   ins_mask_prev;
  logic                  is_full, is_empty;

  assign new_val  = in_value[DATA_WIDTH-1:0];
  assign new_prio = in_priority_req[PRIO_WIDTH-1:0];
  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);

  // Entries are kept in non-decreasing priority order, so the mask of
  // "new item goes at or before here" is a thermometer; its first set bit
  // is the insert slot. Empty slots count as set.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ins_mask[i] = (CNT_W'(i) >= count_r) || (new_prio <= prio_r[i]);
    end
    ins_mask_prev = {ins_mask[CAPACITY-2:0], 1'b0};
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      val_nxt[i]  = val_r[i];
      prio_nxt[i] = prio_r[i];
    end
    count_nxt      = count_r;
    res_value_nxt  = '0;
    res_status_nxt = ST_OK;

    if (in_func == FUNC_INSERT) begin
      if (is_full) begin
        res_status_nxt = ST_FULL;
      end else begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (ins_mask[i] && !ins_mask_prev[i]) begin
            val_nxt[i]  = new_val;
            prio_nxt[i] = new_prio;
          end
        end
        for (int i = 1; i < CAPACITY; i++) begin
          if (ins_mask_prev[i]) begin
            val_nxt[i]  = val_r[i-1];
            prio_nxt[i] = prio_r[i-1];
          end
        end
        count_nxt = count_r + 1'b1;
      end
    end else begin
      if (is_empty) begin
        res_status_nxt = ST_EMPTY;
      end else begin
        res_value_nxt = val_r[0];
        for (int i = 0; i < CAPACITY - 1; i++) begin
          val_nxt[i]  = val_r[i+1];
          prio_nxt[i] = prio_r[i+1];
        end
        count_nxt = count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        val_r[i]  <= val_nxt[i];
        prio_r[i] <= prio_nxt[i];
      end
      res_value_r  <= res_value_nxt;
      res_status_r <= res_status_nxt;
      res_count_r  <= count_nxt;
    end
  end

  assign out_value     = 32'(res_value_r);
  assign out_status    = res_status_r;
  assign out_occupancy = 5'(res_count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && in_func == FUNC_INSERT && !is_full) |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not add an entry");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && in_func == FUNC_REMOVE && !is_empty) |=> count_r == $past(count_r) - 1'b1)
    else $error("remove did not take an entry");

  a_refused_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && ((in_func == FUNC_INSERT && is_full) || (in_func == FUNC_REMOVE && is_empty)))
      |=> (count_r == $past(count_r) && res_value_r == '0))
    else $error("refused item altered the queue");

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Fixed-capacity priority queue held in sorted order.
// ----------------------------------------------------------------------------
// Each item is an insert (value with priority) or a remove of the head entry,
// and each gives one result: the removed value, a status code and the entry
// count after the item. The smallest priority number leaves first; among
// equal priorities the newest leaves first. Inserts into a full queue and
// removes from an empty one are refused with a status code and leave the
// queue unchanged. An item is processed in the cycle it is transferred: all
// stored entries are compared against the new priority in parallel and
// shifted in one step, and the result lands in an output register, so a new
// item is taken every cycle for as long as the result side keeps up. The
// result is valid in the cycle after its input transfer.
// ----------------------------------------------------------------------------
module sorted_priority_queue import spq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [31:0] in_value,
  input  logic [15:0] in_priority_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value,
  output logic [1:0]  out_status,
  output logic [4:0]  out_occupancy
);

  spq_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  spq_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_func         (in_func),
    .in_value        (in_value),
    .in_priority_req (in_priority_req),
    .out_value       (out_value),
    .out_status      (out_status),
    .out_occupancy   (out_occupancy)
  );

endmodule

// ===== verif/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// Watches both channels of the sorted priority queue, keeps its own copy of
// the queue contents, predicts one result per input transfer and compares
// each result transfer with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module spq_checker import spq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_func,
  input  logic [DATA_WIDTH-1:0] in_value,
  input  logic [PRIO_WIDTH-1:0] in_priority_req,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [DATA_WIDTH-1:0] out_value,
  input  logic [1:0]            out_status,
  input  logic [CNT_W-1:0]      out_occupancy,
  output int                    mismatches,
  output int                    results_pending
);

  typedef struct packed {
    logic [DATA_WIDTH-1:0] value;
    status_t               status;
    logic [CNT_W-1:0]      occupancy;
  } queue_result_t;

  logic [DATA_WIDTH-1:0] held_value [CAPACITY];
  logic [PRIO_WIDTH-1:0] held_prio  [CAPACITY];
  int                    held_count = 0;
  int                    fault_count = 0;
  queue_result_t         expected_results [$];

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fault_count++;
  endtask

  // Applies one operation to the held queue and returns the result it gives.
  function automatic queue_result_t apply_queue_op(input func_t op,
                                                   input logic [DATA_WIDTH-1:0] v,
                                                   input logic [PRIO_WIDTH-1:0] p);
    queue_result_t r;
    int pos;
    r = '{value: '0, status: ST_OK, occupancy: '0};
    if (op == FUNC_INSERT) begin
      if (held_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // first entry with priority >= p; ties put the newcomer in front
        pos = held_count;
        for (int i = held_count - 1; i >= 0; i--)
          if (p <= held_prio[i]) pos = i;
        for (int i = held_count; i > pos; i--) begin
          held_value[i] = held_value[i-1];
          held_prio[i]  = held_prio[i-1];
        end
        held_value[pos] = v;
        held_prio[pos]  = p;
        held_count++;
      end
    end else if (held_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.value = held_value[0];
      for (int i = 1; i < held_count; i++) begin
        held_value[i-1] = held_value[i];
        held_prio[i-1]  = held_prio[i];
      end
      held_count--;
    end
    r.occupancy = CNT_W'(held_count);
    return r;
  endfunction

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      held_count = 0;
      expected_results.delete();
    end else begin
      // result transfer first: it belongs to an earlier input transfer
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %h status %0d occupancy %0d",
                                    out_value, out_status, out_occupancy));
        end else begin
          want = expected_results.pop_front();
          if (out_value !== want.value)
            report_mismatch($sformatf("value got %h expected %h", out_value, want.value));
          if (out_status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d", out_status, want.status));
          if (out_occupancy !== want.occupancy)
            report_mismatch($sformatf("occupancy got %0d expected %0d",
                                      out_occupancy, want.occupancy));
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(apply_queue_op(func_t'(in_func), in_value,
                                                  in_priority_req));
    end
    results_pending <= expected_results.size();
    mismatches      <= fault_count;
  end

endmodule

// ===== verif/sorted_priority_queue_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Stimulus and verdict for the sorted priority queue.
// ----------------------------------------------------------------------------
// A short directed run covers empty removes, extreme values and priorities and
// ties at head and tail; then bursts of insert-heavy and remove-heavy traffic
// fill and drain the queue repeatedly. Idling moves from a slow receiver to a
// slow sender to none. The checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 150;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_func = 1'b0;
  logic [DATA_WIDTH-1:0] in_value = '0;
  logic [PRIO_WIDTH-1:0] in_priority_req = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DATA_WIDTH-1:0] out_value;
  logic [1:0]            out_status;
  logic [CNT_W-1:0]      out_occupancy;
  int                    mismatches;
  int                    results_pending;
  int                    gap_pct = 6;
  int                    stall_pct = 59;
  int                    idle_cycles = 0;

  always #5 clk = ~clk;

  sorted_priority_queue u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_value       (in_value),
    .in_priority_req(in_priority_req),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_status     (out_status),
    .out_occupancy  (out_occupancy)
  );

  spq_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_value       (in_value),
    .in_priority_req(in_priority_req),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_status     (out_status),
    .out_occupancy  (out_occupancy),
    .mismatches     (mismatches),
    .results_pending(results_pending)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // ends the run when transfers stop on both channels for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input func_t f, input logic [DATA_WIDTH-1:0] v,
                           input logic [PRIO_WIDTH-1:0] p);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= f;
    in_value        <= v;
    in_priority_req <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off the sender until every predicted result has been seen
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  function automatic logic [PRIO_WIDTH-1:0] pick_priority();
    case ($urandom_range(3))
      0:       return PRIO_WIDTH'($urandom_range(3));   // crowd of ties
      1:       return $urandom_range(1) ? '0 : '1;
      default: return PRIO_WIDTH'($urandom);
    endcase
  endfunction

  initial begin
    int sent;
    int burst_len;
    int insert_pct;
    func_t op;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty remove, extremes, ties at head, middle and tail
    send_item(FUNC_REMOVE, 32'h1234_5678, 16'h0000);
    send_item(FUNC_INSERT, 32'h0000_0000, 16'h0000);
    send_item(FUNC_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(FUNC_INSERT, 32'hA5A5_A5A5, 16'h8000);
    send_item(FUNC_INSERT, 32'h5A5A_5A5A, 16'h8000);
    send_item(FUNC_INSERT, 32'h0000_0001, 16'hFFFF);
    send_item(FUNC_INSERT, 32'h0000_0002, 16'h0000);
    repeat (7) send_item(FUNC_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      gap_pct   = (ph == 0) ? 6 : (ph == 1) ? 59 : 0;
      stall_pct = (ph == 0) ? 59 : (ph == 1) ? 6 : 0;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        // long insert-heavy bursts reach full, remove-heavy ones reach empty
        burst_len = $urandom_range(40, 6);
        case ($urandom_range(4))
          0, 1:    insert_pct = 85;
          2, 3:    insert_pct = 20;
          default: insert_pct = 50;
        endcase
        for (int k = 0; k < burst_len && sent < ITEMS_PER_PHASE; k++) begin
          op = ($urandom_range(99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
          send_item(op, $urandom, pick_priority());
          sent++;
        end
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && results_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/sorted_priority_queue.sv
verif/spq_checker.sv
verif/sorted_priority_queue_tb.sv
